// ===== sv/lzwd_pkg.sv =====
// Shared types and constants for the LZW byte decoder.
// No dependencies; imported by the controller, datapath and top level.
package lzwd_pkg;

  localparam int CODE_W = 12;
  localparam int BYTE_W = 8;
  localparam int FREE_W = 13;

  localparam logic [FREE_W-1:0] ROOT_CODES = 13'd256;
  localparam int CODE_SPACE = 4096;

  // Classification of an incoming code against the current dictionary state
  typedef enum logic [1:0] {
    KIND_START_OK,
    KIND_START_BAD,
    KIND_REJECT,
    KIND_WALK
  } item_kind_t;

  // Source of the byte loaded into the output register
  typedef enum logic [1:0] {
    OSEL_STACK,
    OSEL_FIRST,
    OSEL_START,
    OSEL_ERROR
  } out_sel_t;

  typedef struct packed {
    logic     take_item;
    logic     restart_ok;
    logic     restart_bad;
    logic     push;
    logic     pop_load;
    logic     pop;
    logic     out_load;
    out_sel_t out_sel;
    logic     commit;
  } lzwd_cmd_t;

  typedef struct packed {
    item_kind_t kind;
    logic       at_root;
    logic       overflow;
    logic       sp_zero;
    logic       kwk;
    logic       out_free;
  } lzwd_status_t;

endpackage

// ===== sv/lzwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the dictionary and the reversal stack.
module lzwd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lzwd_ctrl.sv =====
// Sequencing state machine of the LZW byte decoder.
// Depends on lzwd_pkg; drives commands into lzwd_datapath and reads its status.
module lzwd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lzwd_pkg::lzwd_status_t status,
  output lzwd_pkg::lzwd_cmd_t    cmd
);
  import lzwd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_WALK      = 7'b0000010,
    S_POP_WAIT  = 7'b0000100,
    S_EMIT      = 7'b0001000,
    S_EXTRA     = 7'b0010000,
    S_COMMIT    = 7'b0100000,
    S_SINGLE    = 7'b1000000
  } state_t;

  state_t   state;
  state_t   state_next;
  out_sel_t single_sel;
  out_sel_t single_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      single_sel <= OSEL_ERROR;
    end else begin
      state      <= state_next;
      single_sel <= single_sel_next;
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.out_sel     = OSEL_STACK;
    state_next      = state;
    single_sel_next = single_sel;
    in_stall        = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          case (status.kind)
            KIND_START_OK: begin
              cmd.restart_ok  = 1'b1;
              single_sel_next = OSEL_START;
              state_next      = S_SINGLE;
            end
            KIND_START_BAD: begin
              cmd.restart_bad = 1'b1;
              single_sel_next = OSEL_ERROR;
              state_next      = S_SINGLE;
            end
            KIND_REJECT: begin
              single_sel_next = OSEL_ERROR;
              state_next      = S_SINGLE;
            end
            KIND_WALK: begin
              state_next = S_WALK;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (status.overflow) begin
          single_sel_next = OSEL_ERROR;
          state_next      = S_SINGLE;
        end else begin
          cmd.push = 1'b1;
          if (status.at_root) begin
            state_next = S_POP_WAIT;
          end
        end
      end
      S_POP_WAIT: begin
        cmd.pop_load = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        cmd.out_sel = OSEL_STACK;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.sp_zero) begin
            state_next = status.kwk ? S_EXTRA : S_COMMIT;
          end else begin
            cmd.pop = 1'b1;
          end
        end
      end
      S_EXTRA: begin
        cmd.out_sel = OSEL_FIRST;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      S_SINGLE: begin
        cmd.out_sel = single_sel;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lzwd_datapath.sv =====
// Datapath of the LZW byte decoder: dictionary, reversal stack, stream state
// and output register. Depends on lzwd_pkg and lzwd_ram.
module lzwd_datapath #(
  parameter int DICT_SIZE      = 4096,
  parameter int MAX_STRING_LEN = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [lzwd_pkg::FREE_W-1:0]         cfg_write_data,
  input  logic [lzwd_pkg::CODE_W-1:0]         code,
  input  logic                                stream_start,
  input  lzwd_pkg::lzwd_cmd_t                 cmd,
  output lzwd_pkg::lzwd_status_t              status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lzwd_pkg::BYTE_W-1:0]         data_byte,
  output logic                                last_byte,
  output logic                                code_error
);
  import lzwd_pkg::*;

  localparam int DictDepth  = (DICT_SIZE < CODE_SPACE) ? DICT_SIZE : CODE_SPACE;
  localparam int AddrW      = $clog2(DictDepth);
  localparam int StackAddrW = $clog2(MAX_STRING_LEN);
  localparam int CntW       = $clog2(MAX_STRING_LEN + 1);
  localparam logic [CntW-1:0]   CapFull  = CntW'(MAX_STRING_LEN);
  localparam logic [CntW-1:0]   CapKwk   = CntW'(MAX_STRING_LEN - 1);
  localparam logic [FREE_W-1:0] LimitTop = FREE_W'(DictDepth);
  localparam int DictW = CODE_W + BYTE_W;

  // Stream state
  logic [FREE_W-1:0] limit;
  logic [FREE_W-1:0] limit_next;
  logic [FREE_W-1:0] next_free;
  logic [CODE_W-1:0] prev_code;
  logic              active;

  // Per-item working registers
  logic [CODE_W-1:0]     code_q;
  logic                  kwk_q;
  logic [CODE_W-1:0]     cur;
  logic [CODE_W-1:0]     cur_next;
  logic [CntW-1:0]       n;
  logic [StackAddrW-1:0] sp;
  logic [StackAddrW-1:0] sp_next;
  logic [BYTE_W-1:0]     first;

  logic [FREE_W-1:0] in_code_ext;
  logic              in_kwk;
  item_kind_t        in_kind;
  logic              at_root;
  logic              overflow;
  logic              out_free;
  logic              dict_grow;

  logic [DictW-1:0]  dict_rdata;
  logic [CODE_W-1:0] dict_prefix;
  logic [BYTE_W-1:0] dict_suffix;
  logic [BYTE_W-1:0] stack_wdata;
  logic [BYTE_W-1:0] stack_rdata;

  // Limit is clamped once, at write time
  always_comb begin
    if (cfg_write_data > LimitTop) begin
      limit_next = LimitTop;
    end else if (cfg_write_data < ROOT_CODES) begin
      limit_next = ROOT_CODES;
    end else begin
      limit_next = cfg_write_data;
    end
  end

  assign in_code_ext = {1'b0, code};
  assign in_kwk      = (in_code_ext == next_free);
  assign at_root     = (cur[CODE_W-1:BYTE_W] == '0);
  assign overflow    = (n >= (kwk_q ? CapKwk : CapFull));
  assign out_free    = !out_valid || !out_stall;
  assign dict_grow   = (next_free < limit);

  always_comb begin
    if (stream_start) begin
      in_kind = (code[CODE_W-1:BYTE_W] != '0) ? KIND_START_BAD : KIND_START_OK;
    end else if (!active || (in_code_ext > next_free)) begin
      in_kind = KIND_REJECT;
    end else if (in_kwk && (next_free >= limit)) begin
      in_kind = KIND_REJECT;
    end else begin
      in_kind = KIND_WALK;
    end
  end

  assign status.kind     = in_kind;
  assign status.at_root  = at_root;
  assign status.overflow = overflow;
  assign status.sp_zero  = (sp == '0);
  assign status.kwk      = kwk_q;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LimitTop;
      next_free <= ROOT_CODES;
      prev_code <= '0;
      active    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        limit <= limit_next;
      end
      if (cmd.restart_ok) begin
        next_free <= ROOT_CODES;
        prev_code <= code;
        active    <= 1'b1;
      end else if (cmd.restart_bad) begin
        next_free <= ROOT_CODES;
        active    <= 1'b0;
      end else if (cmd.commit) begin
        prev_code <= code_q;
        if (dict_grow) begin
          next_free <= next_free + 1'b1;
        end
      end
    end
  end

  // The dictionary read address follows cur_next, so dict_rdata is always
  // the entry of the code held in cur.
  always_comb begin
    cur_next = cur;
    if (cmd.take_item) begin
      cur_next = in_kwk ? prev_code : code;
    end else if (cmd.push) begin
      cur_next = dict_prefix;
    end
  end

  always_comb begin
    sp_next = sp;
    if (cmd.pop_load) begin
      sp_next = StackAddrW'(n - 1'b1);
    end else if (cmd.pop) begin
      sp_next = sp - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    sp  <= sp_next;
    if (cmd.take_item) begin
      code_q <= code;
      kwk_q  <= in_kwk && !stream_start;
      n      <= '0;
    end else if (cmd.push) begin
      n <= n + 1'b1;
    end
    if (cmd.push && at_root) begin
      first <= cur[BYTE_W-1:0];
    end
  end

  assign dict_prefix = dict_rdata[DictW-1:BYTE_W];
  assign dict_suffix = dict_rdata[BYTE_W-1:0];
  assign stack_wdata = at_root ? cur[BYTE_W-1:0] : dict_suffix;

  lzwd_ram #(
    .WIDTH (DictW),
    .DEPTH (DictDepth)
  ) u_dict (
    .clk   (clk),
    .we    (cmd.commit && dict_grow),
    .waddr (next_free[AddrW-1:0]),
    .wdata ({prev_code, first}),
    .raddr (cur_next[AddrW-1:0]),
    .rdata (dict_rdata)
  );

  lzwd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_STRING_LEN)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (n[StackAddrW-1:0]),
    .wdata (stack_wdata),
    .raddr (sp_next),
    .rdata (stack_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OSEL_STACK: begin
          data_byte  <= stack_rdata;
          last_byte  <= (sp == '0) && !kwk_q;
          code_error <= 1'b0;
        end
        OSEL_FIRST: begin
          data_byte  <= first;
          last_byte  <= 1'b1;
          code_error <= 1'b0;
        end
        OSEL_START: begin
          data_byte  <= code_q[BYTE_W-1:0];
          last_byte  <= 1'b1;
          code_error <= 1'b0;
        end
        default: begin
          data_byte  <= '0;
          last_byte  <= 1'b1;
          code_error <= 1'b1;
        end
      endcase
    end
  end

  a_push_within_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !overflow)
    else $error("stack push beyond string bound");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("output register overwritten while held");

  a_next_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= LimitTop)
    else $error("next free code beyond dictionary depth");

endmodule

// ===== sv/lzw_byte_decoder_core.sv =====
// LZW byte decoder. Each accepted code is expanded to its byte string, one
// output transaction per byte with last_byte on the final one; a rejected code
// gives a single transaction with data_byte 0, last_byte 1 and code_error 1.
// One code is in work at a time. The code is accepted, its prefix chain is
// walked at one dictionary RAM read per cycle while each byte is pushed onto
// the reversal stack, and after a turnaround the stack is popped to the output;
// the code-equals-next-free case emits one extra byte, and then the dictionary
// is updated. A start code or a code rejected on arrival gives a single
// transaction; a string over MAX_STRING_LEN is rejected during the walk.
// Output stalls hold the output transactions. Configuration (dictionary_limit)
// must be written by the user only while idle; the block does not enforce it.
// Depends on lzwd_pkg, lzwd_ctrl, lzwd_datapath and lzwd_ram.
module lzw_byte_decoder_core #(
  parameter int DICT_SIZE      = 4096,
  parameter int MAX_STRING_LEN = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [lzwd_pkg::FREE_W-1:0] cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lzwd_pkg::CODE_W-1:0] code,
  input  logic                        stream_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lzwd_pkg::BYTE_W-1:0] data_byte,
  output logic                        last_byte,
  output logic                        code_error
);
  import lzwd_pkg::*;

  lzwd_cmd_t    cmd;
  lzwd_status_t status;

  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lzwd_datapath #(
    .DICT_SIZE      (DICT_SIZE),
    .MAX_STRING_LEN (MAX_STRING_LEN)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .code           (code),
    .stream_start   (stream_start),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .code_error     (code_error)
  );

endmodule
